// ===== hdl/rrjq_pkg.sv =====
// Types, constants and helpers shared by the round-robin job queue.
package rrjq_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int LIFE_BITS    = 10;

  localparam int PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W         = 16;
  localparam int SEQ_W        = ID_W + 1;
  localparam int FLD_LIFE_W   = 10;
  localparam int LIMIT_W      = 7;
  localparam int LIM_CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LIFE_EXT_W   = (LIFE_BITS > FLD_LIFE_W) ? LIFE_BITS : FLD_LIFE_W;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_JOBS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUEUE_LIMIT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_QUANTUM     = 2'd3;

  // Request and policy codes
  localparam logic REQ_PRODUCE = 1'b0;
  localparam logic REQ_SERVE   = 1'b1;
  localparam logic POL_FCFS    = 1'b0;
  localparam logic POL_RR      = 1'b1;

  typedef enum logic [2:0] {
    STAT_PRODUCED  = 3'd0,
    STAT_COMPLETED = 3'd1,
    STAT_REQUEUED  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4,
    STAT_TOTAL     = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                  req_type;
    logic [FLD_LIFE_W-1:0] job_life;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [ID_W-1:0]       job_id;
    logic [FLD_LIFE_W-1:0] work_done;
    logic [FLD_LIFE_W-1:0] life_left;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [LIFE_BITS-1:0] life;
  } job_t;

  function automatic logic [LIFE_EXT_W-1:0] life_ext(input logic [LIFE_BITS-1:0] v);
    return LIFE_EXT_W'(v);
  endfunction

  function automatic logic [LIFE_EXT_W-1:0] fld_ext(input logic [FLD_LIFE_W-1:0] v);
    return LIFE_EXT_W'(v);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + 1'b1;
    return (s >= (PTR_W+1)'(QUEUE_DEPTH)) ? '0 : s[PTR_W-1:0];
  endfunction

endpackage

// ===== hdl/round_robin_job_queue_top.sv =====
// Round-robin job queue: job memory, queue pointers, request sequencer and result register.
//
// The head entry is read from the job store on the request transfer, and the result register
// loads in the execute step after it. The sequencer takes requests only in its idle step, so
// it cannot take a new request before the last one has left the execute step.
// A stalled result register holds the sequencer in its execute step until the result is taken.
// Reset (rst_n, synchronous, active low) clears pointers, counters, config and handshake state;
// the job store is not cleared and takes no clearing pass, only queued entries are ever used.
module round_robin_job_queue_top
  import rrjq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]       total_jobs_r;
  logic [LIMIT_W-1:0]    queue_limit_r;
  logic                  policy_r;
  logic [FLD_LIFE_W-1:0] quantum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_jobs_r  <= '0;
      queue_limit_r <= '0;
      policy_r      <= POL_FCFS;
      quantum_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TOTAL_JOBS:  total_jobs_r  <= cfg_wdata[ID_W-1:0];
        CFG_QUEUE_LIMIT: queue_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_POLICY:      policy_r      <= cfg_wdata[0];
        CFG_QUANTUM:     quantum_r     <= cfg_wdata[FLD_LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Queue state
  // ---------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0]      tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0]      wait_cnt_r, wait_cnt_nxt;
  logic [SEQ_W-1:0]      next_id_r, next_id_nxt;
  logic [SEQ_W-1:0]      done_cnt_r, done_cnt_nxt;
  in_item_t              req_r;
  job_t                  rd_data_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, result;

  logic                  in_xfer;
  logic                  exec_go;

  // store write port, driven in the execute step
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  job_t                  wr_data;

  assign in_xfer = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Job store: one write port, one registered read port.
  // The head entry is read on the request transfer; writes land only in the
  // execute step, when no transfer can happen, so read and write never collide.
  // ---------------------------------------------------------------------------
  job_t job_store [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      job_store[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_data_r <= job_store[head_ptr_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      // the result register must be free (or emptying) to take the new result
      ST_EXEC: exec_go  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Execute step: decide the request against the current queue state
  // ---------------------------------------------------------------------------
  logic [LIM_CMP_W-1:0]  eff_limit;
  logic [LIM_CMP_W-1:0]  cnt_ext;
  logic [LIFE_EXT_W-1:0] life_e, quantum_e, left_e;

  always_comb begin
    // limit of 0 or beyond the memory means the whole memory
    if (queue_limit_r == '0 ||
        LIM_CMP_W'(queue_limit_r) > LIM_CMP_W'(QUEUE_DEPTH)) begin
      eff_limit = LIM_CMP_W'(QUEUE_DEPTH);
    end else begin
      eff_limit = LIM_CMP_W'(queue_limit_r);
    end
    cnt_ext   = LIM_CMP_W'(wait_cnt_r);
    life_e    = life_ext(rd_data_r.life);
    quantum_e = fld_ext(quantum_r);
    left_e    = life_e - quantum_e;

    head_ptr_nxt = head_ptr_r;
    tail_ptr_nxt = tail_ptr_r;
    wait_cnt_nxt = wait_cnt_r;
    next_id_nxt  = next_id_r;
    done_cnt_nxt = done_cnt_r;
    wr_en        = 1'b0;
    wr_addr      = tail_ptr_r;
    wr_data      = rd_data_r;

    result.status    = STAT_TOTAL;
    result.job_id    = '0;
    result.work_done = '0;
    result.life_left = '0;

    if (req_r.req_type == REQ_PRODUCE) begin
      if (next_id_r > SEQ_W'(total_jobs_r)) begin
        result.status = STAT_TOTAL;
      end else if (cnt_ext >= eff_limit) begin
        result.status = STAT_FULL;
      end else begin
        result.status = STAT_PRODUCED;
        result.job_id = next_id_r[ID_W-1:0];
        wr_en         = exec_go;
        wr_data.id    = next_id_r[ID_W-1:0];
        wr_data.life  = LIFE_BITS'(fld_ext(req_r.job_life));
        tail_ptr_nxt  = ptr_inc(tail_ptr_r);
        next_id_nxt   = next_id_r + 1'b1;
        wait_cnt_nxt  = wait_cnt_r + 1'b1;
      end
    end else begin
      if (done_cnt_r >= SEQ_W'(total_jobs_r)) begin
        result.status = STAT_TOTAL;
      end else if (wait_cnt_r == '0) begin
        result.status = STAT_EMPTY;
      end else begin
        result.job_id = rd_data_r.id;
        head_ptr_nxt  = ptr_inc(head_ptr_r);
        if (policy_r == POL_RR && life_e >= quantum_e) begin
          // cut by the quantum and move to the tail; occupancy is unchanged
          result.status    = STAT_REQUEUED;
          result.work_done = quantum_r;
          result.life_left = left_e[FLD_LIFE_W-1:0];
          wr_en            = exec_go;
          wr_data.id       = rd_data_r.id;
          wr_data.life     = left_e[LIFE_BITS-1:0];
          tail_ptr_nxt     = ptr_inc(tail_ptr_r);
        end else begin
          result.status    = STAT_COMPLETED;
          result.work_done = life_e[FLD_LIFE_W-1:0];
          wait_cnt_nxt     = wait_cnt_r - 1'b1;
          done_cnt_nxt     = done_cnt_r + 1'b1;
        end
      end
    end
  end

  // result register: loads on the execute step, drains on a result transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Control and payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_ptr_r  <= '0;
      tail_ptr_r  <= '0;
      wait_cnt_r  <= '0;
      next_id_r   <= SEQ_W'(1);
      done_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        head_ptr_r <= head_ptr_nxt;
        tail_ptr_r <= tail_ptr_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        next_id_r  <= next_id_nxt;
        done_cnt_r <= done_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (exec_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic [CNT_W:0] ptr_sum;
  logic [CNT_W:0] ptr_wrap;

  assign ptr_sum  = (CNT_W+1)'(head_ptr_r) + (CNT_W+1)'(wait_cnt_r);
  assign ptr_wrap = (ptr_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                    ptr_sum - (CNT_W+1)'(QUEUE_DEPTH) : ptr_sum;

  // occupancy never exceeds the memory
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wait_cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("waiting count beyond queue depth");

  // tail sits exactly occupancy entries past head
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_wrap[PTR_W-1:0] == tail_ptr_r)
    else $error("head, tail and waiting count disagree");

  // a produced job raises occupancy by one
  a_produce_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && result.status == STAT_PRODUCED |=> wait_cnt_r == $past(wait_cnt_r) + 1'b1)
    else $error("produce did not grow the queue");

  // a request transfer only happens while no request is in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_EXEC && !in_ready)
    else $error("second request taken while one is in flight");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the round-robin job queue: directed table, then random phases.
module tb;
  import rrjq_pkg::*;

  // Run limit in clock cycles.
  localparam int RUN_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_TOTAL_JOBS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  round_robin_job_queue_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue: registers, job slots, pointers and counters.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0]       q_total   = '0;
  logic [LIMIT_W-1:0]    q_limit   = '0;
  logic                  q_policy  = POL_FCFS;
  logic [FLD_LIFE_W-1:0] q_quantum = '0;

  logic [ID_W-1:0]       slot_id   [QUEUE_DEPTH];
  logic [LIFE_BITS-1:0]  slot_life [QUEUE_DEPTH];
  logic [PTR_W-1:0]      head_slot   = '0;
  logic [PTR_W-1:0]      tail_slot   = '0;
  logic [CNT_W-1:0]      jobs_waiting = '0;
  logic [SEQ_W-1:0]      id_next     = SEQ_W'(1);
  logic [SEQ_W-1:0]      jobs_done   = '0;

  // Outcomes of transferred requests, oldest first, waiting for their result transfer.
  out_item_t job_outcomes [$];
  out_item_t oldest_outcome;

  int idle_pct   = 0;   // chance per cycle that the request side holds off
  int stall_pct  = 0;   // chance per cycle that the result side is not ready
  int mismatches = 0;
  int requests   = 0;
  int results    = 0;
  int cycles     = 0;
  int tally [8];        // results seen, by status code

  // Work out what one request does to the queue and what result it reports.
  // QUEUE_DEPTH is a power of two, so the slot pointers simply wrap.
  function automatic out_item_t request_outcome(in_item_t req);
    out_item_t            r;
    int                   cap;
    logic [LIFE_BITS-1:0] life;
    r   = '0;
    cap = (q_limit == 0 || int'(q_limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(q_limit);
    if (req.req_type == REQ_PRODUCE) begin
      // total check wins over the full check
      if (int'(id_next) > int'(q_total)) begin
        r.status = STAT_TOTAL;
      end else if (int'(jobs_waiting) >= cap) begin
        r.status = STAT_FULL;
      end else begin
        r.status             = STAT_PRODUCED;
        r.job_id             = id_next[ID_W-1:0];
        slot_id[tail_slot]   = id_next[ID_W-1:0];
        slot_life[tail_slot] = req.job_life;
        tail_slot            = tail_slot + 1'b1;
        id_next              = id_next + 1'b1;
        jobs_waiting         = jobs_waiting + 1'b1;
      end
    end else begin
      if (int'(jobs_done) >= int'(q_total)) begin
        r.status = STAT_TOTAL;
      end else if (jobs_waiting == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        life      = slot_life[head_slot];
        r.job_id  = slot_id[head_slot];
        head_slot = head_slot + 1'b1;
        if (q_policy == POL_RR && life >= q_quantum) begin
          // cut by one quantum and sent to the back; a zero quantum cycles forever
          r.status             = STAT_REQUEUED;
          r.work_done          = q_quantum;
          r.life_left          = life - q_quantum;
          slot_id[tail_slot]   = r.job_id;
          slot_life[tail_slot] = r.life_left;
          tail_slot            = tail_slot + 1'b1;
        end else begin
          r.status     = STAT_COMPLETED;
          r.work_done  = life;
          jobs_waiting = jobs_waiting - 1'b1;
          jobs_done    = jobs_done + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order comparison.
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results++;
      tally[out_data.status]++;
      if (job_outcomes.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding, status %0d id %0d",
                 $time, out_data.status, out_data.job_id);
        mismatches++;
      end else begin
        oldest_outcome = job_outcomes[0];
        job_outcomes.delete(0);
        check_field("status",    oldest_outcome.status,    out_data.status);
        check_field("job_id",    oldest_outcome.job_id,    out_data.job_id);
        check_field("work_done", oldest_outcome.work_done, out_data.work_done);
        check_field("life_left", oldest_outcome.life_left, out_data.life_left);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d results outstanding",
               $time, RUN_LIMIT, job_outcomes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and register writes.
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until the transfer; valid stays high into the
  // next call unless that call opens a gap. A typed result replaces the predicted one.
  task automatic offer_request(in_item_t req, bit typed, out_item_t want);
    int        gap = 0;
    out_item_t predicted;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = request_outcome(req);
    job_outcomes.insert(job_outcomes.size(), typed ? want : predicted);
    requests++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_outcomes();
    in_valid <= 1'b0;
    while (job_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_we after the last write of a batch.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      CFG_TOTAL_JOBS:  q_total   = val[ID_W-1:0];
      CFG_QUEUE_LIMIT: q_limit   = val[LIMIT_W-1:0];
      CFG_POLICY:      q_policy  = val[0];
      CFG_QUANTUM:     q_quantum = val[FLD_LIFE_W-1:0];
      default: ;
    endcase
  endtask

  // One random phase: reprogram while idle, then a burst of mixed requests.
  // Lives lean on the extremes and on the quantum boundary.
  task automatic run_phase(int n, int total, int limit, bit pol, int quant,
                           int send_idle, int recv_stall, int serve_pct);
    in_item_t req;
    drain_outcomes();
    write_reg(CFG_TOTAL_JOBS, total);
    write_reg(CFG_QUEUE_LIMIT, limit);
    write_reg(CFG_POLICY, pol);
    write_reg(CFG_QUANTUM, quant);
    cfg_we    <= 1'b0;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < n; i++) begin
      req.req_type = ($urandom_range(0, 99) < serve_pct) ? REQ_SERVE : REQ_PRODUCE;
      case ($urandom_range(0, 7))
        0:       req.job_life = '0;
        1:       req.job_life = '1;
        2:       req.job_life = q_quantum;
        3:       req.job_life = q_quantum - 1'b1;
        default: req.job_life = FLD_LIFE_W'($urandom_range(0, 1023));
      endcase
      offer_request(req, 1'b0, '0);
      // now and then hold off until the queue has answered everything
      if ($urandom_range(0, 59) == 0) drain_outcomes();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Register rows are applied only with nothing outstanding.
  // Typed rows carry a written-out expected result; the rest are predicted.
  // Sequence: total reached from reset, empty serve, full at limit 2, limit 0 as
  // whole memory, produce past total, RR cut at quantum 1000, zero quantum
  // requeue, completions at quantum 1023, serve past total, limit above memory.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] value;
    in_item_t              req;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  localparam int PLAN_ROWS = 28;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_REG, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd0},    1'b1,
      '{STAT_TOTAL, 16'd0, 10'd0, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd1023},   1'b1,
      '{STAT_TOTAL, 16'd0, 10'd0, 10'd0}},
    '{ROW_REG, CFG_TOTAL_JOBS,  16'd3,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_EMPTY, 16'd0, 10'd0, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd1023}, 1'b1,
      '{STAT_PRODUCED, 16'd1, 10'd0, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd0},    1'b1,
      '{STAT_PRODUCED, 16'd2, 10'd0, 10'd0}},
    '{ROW_REG, CFG_QUEUE_LIMIT, 16'd2,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd5},    1'b1,
      '{STAT_FULL, 16'd0, 10'd0, 10'd0}},
    '{ROW_REG, CFG_QUEUE_LIMIT, 16'd0,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd5},    1'b1,
      '{STAT_PRODUCED, 16'd3, 10'd0, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'h2AA},  1'b1,
      '{STAT_TOTAL, 16'd0, 10'd0, 10'd0}},
    '{ROW_REG, CFG_POLICY,      16'd1,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REG, CFG_QUANTUM,     16'd1000,  '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'h155},    1'b1,
      '{STAT_REQUEUED, 16'd1, 10'd1000, 10'd23}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_COMPLETED, 16'd2, 10'd0, 10'd0}},
    '{ROW_REG, CFG_QUANTUM,     16'd0,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_REQUEUED, 16'd3, 10'd0, 10'd5}},
    '{ROW_REG, CFG_QUANTUM,     16'd1023,  '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_COMPLETED, 16'd1, 10'd23, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_COMPLETED, 16'd3, 10'd5, 10'd0}},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b1,
      '{STAT_TOTAL, 16'd0, 10'd0, 10'd0}},
    '{ROW_REG, CFG_TOTAL_JOBS,  16'd65535, '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REG, CFG_QUEUE_LIMIT, 16'd127,   '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REG, CFG_POLICY,      16'd0,     '{REQ_PRODUCE, 10'd0},    1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_PRODUCE, 10'd1023}, 1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b0, '0},
    '{ROW_REQ, CFG_TOTAL_JOBS,  16'd0,     '{REQ_SERVE, 10'd0},      1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int grant_total;
    foreach (tally[i]) tally[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling on either side
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (r > 0 && plan[r-1].kind == ROW_REQ) drain_outcomes();
        write_reg(plan[r].addr, plan[r].value);
      end else begin
        cfg_we <= 1'b0;
        offer_request(plan[r].req, plan[r].typed, plan[r].want);
      end
    end

    // random phases:  n   total  limit  policy  quantum          idle stall serve%
    run_phase(240, 65535,   0, POL_FCFS,    0,                      0,  0, 35);
    run_phase(220, 65535,   8, POL_RR,   $urandom_range(50, 400),  69,  0, 55);
    run_phase(200, 65535,  64, POL_RR,      0,                      0, 69, 50);
    run_phase(200, 65535,   1, POL_FCFS, 1023,                     22, 22, 45);
    run_phase(240, 65535, 127, POL_RR,   1023,                      0,  0, 60);
    // a total just a dozen jobs ahead, so produce and serve both run into it
    drain_outcomes();
    grant_total = int'(id_next) - 1 + 12;
    if (grant_total > 65535) grant_total = 65535;
    run_phase(200, grant_total, 20, POL_RR, 300,                   22, 69, 50);
    // total lowered to the jobs already done: every request is turned away
    drain_outcomes();
    run_phase(60, int'(jobs_done), 64, POL_FCFS, 512,              69, 22, 50);
    run_phase(270, 65535, $urandom_range(2, 64), POL_RR, $urandom_range(1, 1022),
              0, 69, 50);

    drain_outcomes();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests over a directed table and eight random phases (FCFS and RR,",
             requests);
    $display("  quanta 0..1023, limits 0..127); %0d results: %0d produced, %0d completed,",
             results, tally[STAT_PRODUCED], tally[STAT_COMPLETED]);
    $display("  %0d requeued, %0d full, %0d empty, %0d total",
             tally[STAT_REQUEUED], tally[STAT_FULL], tally[STAT_EMPTY], tally[STAT_TOTAL]);
    if (mismatches == 0 && job_outcomes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rrjq_pkg.sv
hdl/round_robin_job_queue_top.sv
dv/tb.sv
